// ===== rtl/stl_pkg.sv =====
`default_nettype none

package stl_pkg;

    localparam logic [1:0] CMD_BEGIN_PASS = 2'd0;
    localparam logic [1:0] CMD_SIGHTING   = 2'd1;
    localparam logic [1:0] CMD_EXPIRE     = 2'd2;

    localparam logic [2:0] STATUS_REFRESHED  = 3'd0;
    localparam logic [2:0] STATUS_APPENDED   = 3'd1;
    localparam logic [2:0] STATUS_REPLACED   = 3'd2;
    localparam logic [2:0] STATUS_DROPPED    = 3'd3;
    localparam logic [2:0] STATUS_PASS_BEGUN = 3'd4;
    localparam logic [2:0] STATUS_EXPIRED    = 3'd5;

    localparam int TTL_RESET = 10000;

    typedef struct packed {
        logic [15:0] key;
        logic [7:0]  kind;
        logic [7:0]  team;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] health;
        logic        visible;
        logic [47:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic key_eq;
        logic older;
        logic stale;
    } cmp_res_t;

endpackage

`default_nettype wire

// ===== rtl/sighting_table_lru_ttl.sv =====
`default_nettype none

// Table of up to TABLE_ENTRIES sighted entities, kept densely in one memory with a
// registered read port. Each item is worked by a sequencer that walks the table through
// one shared compare unit, so the block takes one item at a time. A sighting makes one
// read per entry, pipelined, then at most one write. A begin pass makes a read and a
// write-back per entry. An expire reads and checks each entry held before it; a stale
// entry is overwritten by the last entry, which is then checked in its place.
// The next item is taken while the previous result still waits on the output register.
// The ttl_reg register resets to 10000; the user must write it through cfg_wr_en and
// cfg_wr_data only while the block is idle, which the block itself does not enforce.
module sighting_table_lru_ttl
    import stl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [15:0] s_key,
    input  wire logic [7:0]  s_kind,
    input  wire logic [7:0]  s_team,
    input  wire logic [23:0] s_pos_x,
    input  wire logic [23:0] s_pos_y,
    input  wire logic [23:0] s_health,
    input  wire logic [47:0] s_now,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [3:0]       m_entry_index,
    output logic [4:0]       m_entry_count,
    output logic [4:0]       m_removed_count
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_CLR_RD  = 3'd2;
    localparam logic [2:0] S_CLR_WR  = 3'd3;
    localparam logic [2:0] S_EXP_RD  = 3'd4;
    localparam logic [2:0] S_EXP_CHK = 3'd5;
    localparam logic [2:0] S_EXP_MOV = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [47:0]      best_stamp_reg, best_stamp_next;
    logic [15:0]      best_key_reg, best_key_next;
    logic             best_vis_reg, best_vis_next;
    logic [2:0]       res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [31:0]      ttl_reg;
    logic             m_valid_reg, m_valid_next;
    logic [2:0]       m_status_reg;
    logic [3:0]       m_index_reg;
    logic [4:0]       m_count_reg;
    logic [4:0]       m_removed_reg;

    logic [15:0]      it_key_reg;
    logic [7:0]       it_kind_reg;
    logic [7:0]       it_team_reg;
    logic [23:0]      it_pos_x_reg;
    logic [23:0]      it_pos_y_reg;
    logic [23:0]      it_health_reg;
    logic [47:0]      it_now_reg;

    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    entry_t           ram_wr_data;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    entry_t           ram_rd_data;
    entry_t           new_entry;
    entry_t           clr_entry;
    cmp_res_t         cmp;

    logic             accept;
    logic             out_load;
    logic             scan_issue;
    logic             exp_more;
    logic             exp_last;
    logic [IDX_W+3:0] idx_ext;
    logic [CNT_W+4:0] count_ext;
    logic [CNT_W+4:0] removed_ext;

    stl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    stl_cmp_unit u_cmp (
        .ent       (ram_rd_data),
        .key       (it_key_reg),
        .now       (it_now_reg),
        .best_key  (best_key_reg),
        .best_stamp(best_stamp_reg),
        .ttl       (ttl_reg),
        .res       (cmp)
    );

    always_comb begin
        new_entry.key     = it_key_reg;
        new_entry.kind    = it_kind_reg;
        new_entry.team    = it_team_reg;
        new_entry.pos_x   = it_pos_x_reg;
        new_entry.pos_y   = it_pos_y_reg;
        new_entry.health  = it_health_reg;
        new_entry.visible = 1'b1;
        new_entry.stamp   = it_now_reg;
        clr_entry         = ram_rd_data;
        clr_entry.visible = 1'b0;
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_load   = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign scan_issue = (i_reg < count_reg);
    assign exp_more   = (i_reg < count_reg);
    assign exp_last   = ((i_reg + CNT_W'(1)) == count_reg);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        removed_next    = removed_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        best_key_next   = best_key_reg;
        best_vis_next   = best_vis_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = i_reg[IDX_W-1:0];
        ram_wr_data     = new_entry;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = i_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    i_next       = '0;
                    removed_next = '0;
                    hit_next     = 1'b0;
                    res_idx_next = '0;
                    case (s_cmd)
                        CMD_BEGIN_PASS: begin
                            res_status_next = STATUS_PASS_BEGUN;
                            state_next      = S_CLR_RD;
                        end
                        CMD_SIGHTING: begin
                            state_next = S_SCAN;
                        end
                        CMD_EXPIRE: begin
                            res_status_next = STATUS_EXPIRED;
                            state_next      = S_EXP_RD;
                        end
                        default: begin
                            res_status_next = STATUS_EXPIRED;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_issue) begin
                    ram_rd_en     = 1'b1;
                    i_next        = i_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = i_reg[IDX_W-1:0];
                end
                if (pend_reg) begin
                    if (cmp.key_eq && !hit_reg) begin
                        hit_next     = 1'b1;
                        hit_idx_next = pend_idx_reg;
                    end
                    if ((pend_idx_reg == '0) || cmp.older) begin
                        best_idx_next   = pend_idx_reg;
                        best_stamp_next = ram_rd_data.stamp;
                        best_key_next   = ram_rd_data.key;
                        best_vis_next   = ram_rd_data.visible;
                    end
                end
                if (!scan_issue && !pend_reg) begin
                    state_next = S_DONE;
                    if (hit_reg) begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = hit_idx_reg;
                        res_idx_next    = hit_idx_reg;
                        res_status_next = STATUS_REFRESHED;
                    end else if (count_reg < CNT_W'(TABLE_ENTRIES)) begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = count_reg[IDX_W-1:0];
                        res_idx_next    = count_reg[IDX_W-1:0];
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = STATUS_APPENDED;
                    end else if (best_vis_reg) begin
                        res_status_next = STATUS_DROPPED;
                    end else begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = best_idx_reg;
                        res_idx_next    = best_idx_reg;
                        res_status_next = STATUS_REPLACED;
                    end
                end
            end
            S_CLR_RD: begin
                if (exp_more) begin
                    ram_rd_en  = 1'b1;
                    state_next = S_CLR_WR;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_CLR_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = clr_entry;
                i_next      = i_reg + CNT_W'(1);
                state_next  = S_CLR_RD;
            end
            S_EXP_RD: begin
                if (exp_more) begin
                    ram_rd_en  = 1'b1;
                    state_next = S_EXP_CHK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_EXP_CHK: begin
                if (!cmp.stale) begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_EXP_RD;
                end else if (exp_last) begin
                    count_next   = count_reg - CNT_W'(1);
                    removed_next = removed_reg + CNT_W'(1);
                    state_next   = S_EXP_RD;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = IDX_W'(count_reg - CNT_W'(1));
                    state_next  = S_EXP_MOV;
                end
            end
            S_EXP_MOV: begin
                // The last entry now sits in the read register and is examined in place.
                ram_wr_en    = 1'b1;
                ram_wr_data  = ram_rd_data;
                count_next   = count_reg - CNT_W'(1);
                removed_next = removed_reg + CNT_W'(1);
                state_next   = S_EXP_CHK;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        idx_ext     = {4'd0, res_idx_reg};
        count_ext   = {5'd0, count_reg};
        removed_ext = {5'd0, removed_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            ttl_reg     <= 32'(TTL_RESET);
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                ttl_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg          <= i_next;
        removed_reg    <= removed_next;
        pend_idx_reg   <= pend_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        best_key_reg   <= best_key_next;
        best_vis_reg   <= best_vis_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        if (accept) begin
            it_key_reg    <= s_key;
            it_kind_reg   <= s_kind;
            it_team_reg   <= s_team;
            it_pos_x_reg  <= s_pos_x;
            it_pos_y_reg  <= s_pos_y;
            it_health_reg <= s_health;
            it_now_reg    <= s_now;
        end
        if (out_load) begin
            m_status_reg  <= res_status_reg;
            m_index_reg   <= idx_ext[3:0];
            m_count_reg   <= count_ext[4:0];
            m_removed_reg <= removed_ext[4:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_entry_index   = m_index_reg;
    assign m_entry_count   = m_count_reg;
    assign m_removed_count = m_removed_reg;

endmodule

`default_nettype wire

// ===== rtl/stl_ram.sv =====
`default_nettype none

module stl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stl_cmp_unit.sv =====
`default_nettype none

module stl_cmp_unit
    import stl_pkg::*;
(
    input  wire entry_t        ent,
    input  wire logic [15:0]   key,
    input  wire logic [47:0]   now,
    input  wire logic [15:0]   best_key,
    input  wire logic [47:0]   best_stamp,
    input  wire logic [31:0]   ttl,
    output cmp_res_t           res
);

    logic [48:0] age;

    // An entry stamped after the current time makes the age subtraction borrow and is never stale.
    assign age = {1'b0, now} - {1'b0, ent.stamp};

    always_comb begin
        res.key_eq = (ent.key == key);
        res.older  = (ent.stamp < best_stamp) ||
                     ((ent.stamp == best_stamp) && (ent.key > best_key));
        res.stale  = !age[48] && (age[47:0] > {16'd0, ttl});
    end

endmodule

`default_nettype wire

// ===== rtl/stl_chk.sv =====
`default_nettype none

module stl_chk
    import stl_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [3:0]  m_entry_index,
    input wire logic [4:0]  m_entry_count,
    input wire logic [4:0]  m_removed_count
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_entry_index)
            && $stable(m_entry_count) && $stable(m_removed_count))
        else $error("An item held on the result channel changed before it was taken.");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= STATUS_EXPIRED)
        else $error("A result carries an unknown status.");

    a_removed_only_expire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_EXPIRED) |-> m_removed_count == 5'd0)
        else $error("Entries are reported removed by a command other than expire.");

    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == STATUS_DROPPED) || (m_status == STATUS_PASS_BEGUN)
            || (m_status == STATUS_EXPIRED)) |-> m_entry_index == 4'd0)
        else $error("A result that writes no entry carries a nonzero index.");

endmodule

bind sighting_table_lru_ttl stl_chk u_stl_chk (.*);

`default_nettype wire

// ===== test/tb_sighting_table_lru_ttl.sv =====
`default_nettype none

module tb_sighting_table_lru_ttl;
    timeunit 1ns;
    timeprecision 1ps;
    import stl_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_POOL = 24;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int IDLE_TAIL = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] key;
        logic [7:0]  kind;
        logic [7:0]  team;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] health;
        logic [47:0] now;
    } table_op_t;

    typedef struct {
        logic [2:0] status;
        logic [3:0] index;
        logic [4:0] count;
        logic [4:0] removed;
    } table_report_t;

    class sighting_scoreboard;
        entry_t          rows [TABLE_ENTRIES];
        int unsigned     fill;
        logic [31:0]     ttl;
        table_report_t   awaited_reports [$];
        int unsigned     errors;

        function new();
            fill = 0;
            ttl = TTL_RESET;
            errors = 0;
        endfunction

        function void set_ttl(input logic [31:0] value);
            ttl = value;
        endfunction

        function int unsigned pending();
            return awaited_reports.size();
        endfunction

        function void note_item(input table_op_t op);
            table_report_t rep;
            entry_t        fresh;
            int unsigned   i;
            int unsigned   hit_at;
            int unsigned   oldest;
            bit            hit;
            logic [47:0]   age;

            rep.status = STATUS_EXPIRED;
            rep.index = '0;
            rep.removed = '0;
            fresh.key = op.key;
            fresh.kind = op.kind;
            fresh.team = op.team;
            fresh.pos_x = op.pos_x;
            fresh.pos_y = op.pos_y;
            fresh.health = op.health;
            fresh.visible = 1'b1;
            fresh.stamp = op.now;
            case (op.cmd)
                CMD_BEGIN_PASS: begin
                    for (i = 0; i < fill; i++)
                        rows[i].visible = 1'b0;
                    rep.status = STATUS_PASS_BEGUN;
                end
                CMD_SIGHTING: begin
                    hit = 1'b0;
                    hit_at = 0;
                    for (i = 0; i < fill; i++) begin
                        if (!hit && rows[i].key == op.key) begin
                            hit = 1'b1;
                            hit_at = i;
                        end
                    end
                    if (hit) begin
                        rows[hit_at] = fresh;
                        rep.index = 4'(hit_at);
                        rep.status = STATUS_REFRESHED;
                    end else if (fill < TABLE_ENTRIES) begin
                        rows[fill] = fresh;
                        rep.index = 4'(fill);
                        fill++;
                        rep.status = STATUS_APPENDED;
                    end else begin
                        oldest = 0;
                        for (i = 1; i < fill; i++) begin
                            if (rows[i].stamp < rows[oldest].stamp ||
                                (rows[i].stamp == rows[oldest].stamp &&
                                 rows[i].key > rows[oldest].key))
                                oldest = i;
                        end
                        if (rows[oldest].visible) begin
                            rep.status = STATUS_DROPPED;
                        end else begin
                            rows[oldest] = fresh;
                            rep.index = 4'(oldest);
                            rep.status = STATUS_REPLACED;
                        end
                    end
                end
                CMD_EXPIRE: begin
                    i = 0;
                    while (i < fill) begin
                        age = (op.now >= rows[i].stamp) ? op.now - rows[i].stamp : '0;
                        if (age > {16'd0, ttl}) begin
                            rows[i] = rows[fill - 1];
                            fill--;
                            rep.removed++;
                        end else begin
                            i++;
                        end
                    end
                end
                default: begin
                end
            endcase
            rep.count = 5'(fill);
            awaited_reports.push_back(rep);
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(input table_report_t got);
            table_report_t want;

            if (awaited_reports.size() == 0) begin
                $display("%0t: result with none awaited, expected nothing, actual status %0d",
                         $time, got.status);
                errors++;
                return;
            end
            want = awaited_reports.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("entry_index", want.index, got.index);
            compare_field("entry_count", want.count, got.count);
            compare_field("removed_count", want.removed, got.removed);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [15:0] s_key;
    logic [7:0]  s_kind;
    logic [7:0]  s_team;
    logic [23:0] s_pos_x;
    logic [23:0] s_pos_y;
    logic [23:0] s_health;
    logic [47:0] s_now;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [3:0]  m_entry_index;
    logic [4:0]  m_entry_count;
    logic [4:0]  m_removed_count;

    sighting_scoreboard sb;
    logic [47:0] clock_ms;
    logic [31:0] ttl_now;
    logic [15:0] key_pool [KEY_POOL];
    bit          calm_sender;
    bit          calm_receiver = 1'b0;
    int          stall_left = 0;
    int          cycle_count;

    sighting_table_lru_ttl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_key(s_key),
        .s_kind(s_kind),
        .s_team(s_team),
        .s_pos_x(s_pos_x),
        .s_pos_y(s_pos_y),
        .s_health(s_health),
        .s_now(s_now),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_entry_index(m_entry_index),
        .m_entry_count(m_entry_count),
        .m_removed_count(m_removed_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic table_op_t make_op(input logic [1:0] cmd, input logic [15:0] key,
                                          input logic [47:0] now);
        table_op_t op;

        op.cmd = cmd;
        op.key = key;
        op.kind = 8'($urandom);
        op.team = 8'($urandom);
        op.pos_x = 24'($urandom);
        op.pos_y = 24'($urandom);
        op.health = 24'($urandom);
        op.now = now;
        return op;
    endfunction

    function automatic table_op_t next_random_op();
        int unsigned r;
        logic [15:0] key;
        logic [1:0]  cmd;

        r = $urandom_range(0, 99);
        if (r >= 15 && r < 55)
            clock_ms += 48'($urandom_range(0, ttl_now / 8));
        else if (r >= 55 && r < 83)
            clock_ms += 48'($urandom_range(0, ttl_now / 2));
        else if (r >= 83 && r < 93)
            clock_ms += 48'(ttl_now) + 48'($urandom_range(0, 3));
        else if (r >= 93 && r < 97)
            clock_ms -= 48'($urandom_range(1, 5000));
        else if (r >= 97)
            clock_ms = {16'($urandom), $urandom};
        if ($urandom_range(0, 99) < 80)
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        else
            key = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 68)
            cmd = CMD_SIGHTING;
        else if (r < 82)
            cmd = CMD_EXPIRE;
        else if (r < 96)
            cmd = CMD_BEGIN_PASS;
        else
            cmd = CMD_RESERVED;
        return make_op(cmd, key, clock_ms);
    endfunction

    task automatic send(input table_op_t op);
        int gap;

        gap = calm_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= op.cmd;
        s_key <= op.key;
        s_kind <= op.kind;
        s_team <= op.team;
        s_pos_x <= op.pos_x;
        s_pos_y <= op.pos_y;
        s_health <= op.health;
        s_now <= op.now;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_item(op);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (IDLE_TAIL) @(posedge aclk);
    endtask

    task automatic write_ttl(input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_ttl(value);
        ttl_now = value;
    endtask

    task automatic run_directed();
        table_op_t op;

        send(make_op(CMD_EXPIRE, 16'h0000, 48'd0));
        send(make_op(CMD_BEGIN_PASS, 16'h0000, 48'd0));
        send(make_op(CMD_RESERVED, 16'hFFFF, 48'd0));
        op = make_op(CMD_SIGHTING, 16'h0000, 48'd100);
        op.kind = 8'h00;
        op.team = 8'h00;
        op.pos_x = 24'h800000;
        op.pos_y = 24'h7FFFFF;
        op.health = 24'h000000;
        send(op);
        op = make_op(CMD_SIGHTING, 16'hFFFF, 48'd100);
        op.kind = 8'hFF;
        op.team = 8'hFF;
        op.pos_x = 24'h7FFFFF;
        op.pos_y = 24'h800000;
        op.health = 24'hFFFFFF;
        send(op);
        send(make_op(CMD_SIGHTING, 16'h0000, 48'd200));
        for (int k = 1; k <= 14; k++)
            send(make_op(CMD_SIGHTING, 16'(k), 48'd300));
        // The table is full and its oldest entry is still visible, so the newcomer is dropped.
        send(make_op(CMD_SIGHTING, 16'h1234, 48'd300));
        send(make_op(CMD_BEGIN_PASS, 16'h0000, 48'd300));
        send(make_op(CMD_SIGHTING, 16'h1234, 48'd400));
        send(make_op(CMD_EXPIRE, 16'h0000, 48'd10300));
        // Time runs backwards here, so no entry may age out.
        send(make_op(CMD_EXPIRE, 16'h0000, 48'd50));
    endtask

    task automatic run_random(input logic [31:0] ttl_value);
        write_ttl(ttl_value);
        foreach (key_pool[k])
            key_pool[k] = 16'($urandom);
        clock_ms = {16'($urandom), $urandom};
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 50 == 0)
                calm_sender = ($urandom_range(0, 3) == 0);
            send(next_random_op());
        end
        settle();
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!calm_receiver && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
        end
        if ($urandom_range(0, 199) == 0)
            calm_receiver = !calm_receiver;
    end

    always @(posedge aclk) begin : watch_results
        table_report_t seen;

        if (aresetn && m_valid && m_ready) begin
            seen.status = m_status;
            seen.index = m_entry_index;
            seen.count = m_entry_count;
            seen.removed = m_removed_count;
            sb.check_report(seen);
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("tb_sighting_table_lru_ttl failed");
        $finish;
    end

    initial begin
        sb = new();
        calm_sender = 1'b0;
        ttl_now = TTL_RESET;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_cmd <= CMD_BEGIN_PASS;
        s_key <= '0;
        s_kind <= '0;
        s_team <= '0;
        s_pos_x <= '0;
        s_pos_y <= '0;
        s_health <= '0;
        s_now <= '0;
        m_ready <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        settle();
        run_random(32'd0);
        run_random(32'hFFFF_FFFF);
        run_random(32'd1000);
        run_random($urandom);
        run_random(32'd50000);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_sighting_table_lru_ttl passed");
        else
            $display("tb_sighting_table_lru_ttl failed");
        $finish;
    end

endmodule

`default_nettype wire
